// ===== sv/mpv_pkg.sv =====
// Shared constants for the mean and population variance core.
package mpv_pkg;

  // Default buffer depth and sample width.
  localparam int unsigned DEPTH_DEFAULT        = 1024;
  localparam int unsigned SAMPLE_WIDTH_DEFAULT = 16;

  // Width of the variance field, an unsigned integer (Q32.0).
  localparam int unsigned VAR_W = 32;

  // Widest squared-difference accumulator; it saturates at this width.
  localparam int unsigned ACC_MAX_W = 64;

endpackage

// ===== sv/mean_and_population_variance_core.sv =====
// Top level: sample buffer, sequencer, square-and-accumulate pass, shared divider.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+----------------------------------
//   in      | sink      | in_valid_i / in_stall_o | sample_i, last_i
//   out     | source    | out_valid_o/out_stall_i | mean_o, variance_o, overflowed_o
//
// Samples load at one beat per cycle. After the beat flagged last the input
// stalls for two passes through the bit-serial divider (AW accumulator width,
// 45 by default) and one pass over the buffer through the squaring multiplier.
// The result is registered on the edge that ends the stall. Reset clears the
// sequencer and the accumulators; the buffer is not cleared. A finished result
// waits in the output register while the next set loads; a stalled result
// holds the core only when the following set has also finished.
module mean_and_population_variance_core
  import mpv_pkg::*;
#(
  parameter int unsigned DEPTH        = DEPTH_DEFAULT,
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEFAULT
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [SAMPLE_WIDTH-1:0] sample_i,
  input  logic                    last_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [SAMPLE_WIDTH-1:0] mean_o,
  output logic [VAR_W-1:0]        variance_o,
  output logic                    overflowed_o
);

  localparam int unsigned W       = SAMPLE_WIDTH;
  localparam int unsigned CW      = $clog2(DEPTH + 1);
  localparam int unsigned IW      = $clog2(DEPTH);
  localparam int unsigned SW      = W + CW;
  localparam int unsigned MW      = W + 1;
  localparam int unsigned SQW     = 2 * MW;
  localparam int unsigned AW_FULL = SQW + CW;
  localparam int unsigned AW      = (AW_FULL > ACC_MAX_W) ? ACC_MAX_W : AW_FULL;
  localparam int unsigned QW      = (AW > VAR_W) ? AW : VAR_W + 1;

  typedef enum logic [2:0] {
    S_LOAD,
    S_DIVM,
    S_PASS,
    S_DIVV,
    S_DONE
  } state_e;

  state_e               state_q;
  logic [CW-1:0]        count_q;
  logic signed [SW-1:0] sum_q;
  logic                 ovf_q;
  logic                 div_start_q;
  logic signed [W-1:0]  mean_q;
  logic [CW-1:0]        idx_q;
  logic                 rd_v_q;
  logic                 mag_v_q;
  logic                 sq_v_q;
  logic [AW-1:0]        acc_q;
  logic                 out_valid_q;

  logic [W-1:0]         mem_q [DEPTH];
  logic [W-1:0]         rdata_q;
  logic [MW-1:0]        mag_q;
  logic [SQW-1:0]       sq_q;
  logic [W-1:0]         mean_out_q;
  logic [VAR_W-1:0]     var_out_q;
  logic                 ovf_out_q;

  logic                 accept;
  logic                 room;
  logic                 sum_neg;
  logic [SW-1:0]        sum_mag;
  logic [AW-1:0]        div_dividend;
  logic                 div_done;
  logic [AW-1:0]        div_quot;
  logic [W-1:0]         mean_mag;
  logic signed [W-1:0]  mean_d;
  logic signed [W:0]    diff;
  logic [MW-1:0]        mag_d;
  logic [SQW-1:0]       sq_d;
  logic [AW_FULL-1:0]   sq_wide;
  logic [AW:0]          acc_sum;
  logic [AW-1:0]        acc_d;
  logic [QW-1:0]        quot_ext;
  logic [VAR_W-1:0]     var_d;
  logic                 out_free;
  logic                 pass_more;

  // Handshake and buffer room.
  assign in_stall_o = (state_q != S_LOAD);
  assign accept     = in_valid_i && !in_stall_o;
  assign room       = count_q < CW'(DEPTH);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign pass_more  = idx_q < count_q;

  // Magnitude of the running sum for the mean division.
  always_comb begin
    sum_neg      = sum_q[SW-1];
    sum_mag      = sum_neg ? SW'(-sum_q) : SW'(sum_q);
    div_dividend = (state_q == S_DIVM) ? AW'(sum_mag) : acc_q;
  end

  mpv_div #(
    .DIVIDEND_W(AW),
    .DIVISOR_W (CW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start_q),
    .dividend_i(div_dividend),
    .divisor_i (count_q),
    .done_o    (div_done),
    .quotient_o(div_quot)
  );

  // Restore the sign of the mean, truncated toward zero.
  always_comb begin
    mean_mag = div_quot[W-1:0];
    mean_d   = sum_neg ? W'(-mean_mag) : W'(mean_mag);
  end

  // Difference from the mean, its magnitude and square, saturating accumulate.
  always_comb begin
    diff    = {rdata_q[W-1], rdata_q} - {mean_q[W-1], mean_q};
    mag_d   = diff[W] ? MW'(-diff) : MW'(diff);
    sq_d    = SQW'(mag_q) * SQW'(mag_q);
    sq_wide = AW_FULL'(sq_q);
    acc_sum = {1'b0, acc_q} + {1'b0, sq_wide[AW-1:0]};
    acc_d   = acc_sum[AW] ? '1 : acc_sum[AW-1:0];
  end

  // Clamp the variance quotient to the field.
  always_comb begin
    quot_ext = QW'(div_quot);
    var_d    = (|quot_ext[QW-1:VAR_W]) ? '1 : quot_ext[VAR_W-1:0];
  end

  // Sample buffer: write on load, registered read during the pass.
  always_ff @(posedge clk_i) begin
    if (accept && room) begin
      mem_q[count_q[IW-1:0]] <= sample_i;
    end
    rdata_q <= mem_q[idx_q[IW-1:0]];
  end

  // Pass datapath stages.
  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    sq_q  <= sq_d;
  end

  // Sequencer, accumulators and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      count_q     <= '0;
      sum_q       <= '0;
      ovf_q       <= 1'b0;
      div_start_q <= 1'b0;
      mean_q      <= '0;
      idx_q       <= '0;
      rd_v_q      <= 1'b0;
      mag_v_q     <= 1'b0;
      sq_v_q      <= 1'b0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
      mean_out_q  <= '0;
      var_out_q   <= '0;
      ovf_out_q   <= 1'b0;
    end else begin
      div_start_q <= 1'b0;
      rd_v_q      <= 1'b0;
      mag_v_q     <= rd_v_q;
      sq_v_q      <= mag_v_q;
      if (sq_v_q) begin
        acc_q <= acc_d;
      end
      // Drop the result once the beat is taken.
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_LOAD: begin
          if (accept) begin
            if (room) begin
              sum_q   <= sum_q + SW'(signed'(sample_i));
              count_q <= count_q + 1'b1;
            end else begin
              ovf_q <= 1'b1;
            end
            if (last_i) begin
              state_q     <= S_DIVM;
              div_start_q <= 1'b1;
            end
          end
        end
        S_DIVM: begin
          if (div_done) begin
            mean_q  <= mean_d;
            idx_q   <= '0;
            acc_q   <= '0;
            state_q <= S_PASS;
          end
        end
        S_PASS: begin
          // Issue one read a cycle, then wait for the stages to drain.
          if (pass_more) begin
            idx_q  <= idx_q + 1'b1;
            rd_v_q <= 1'b1;
          end else if (!rd_v_q && !mag_v_q && !sq_v_q) begin
            state_q     <= S_DIVV;
            div_start_q <= 1'b1;
          end
        end
        S_DIVV: begin
          if (div_done) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          // Hold until the output register is free, then clear the set.
          if (out_free) begin
            out_valid_q <= 1'b1;
            mean_out_q  <= mean_q;
            var_out_q   <= var_d;
            ovf_out_q   <= ovf_q;
            count_q     <= '0;
            sum_q       <= '0;
            ovf_q       <= 1'b0;
            state_q     <= S_LOAD;
          end
        end
        default: begin
          state_q <= S_LOAD;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign mean_o       = mean_out_q;
  assign variance_o   = var_out_q;
  assign overflowed_o = ovf_out_q;

endmodule

// ===== sv/mpv_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
module mpv_div #(
  parameter int unsigned DIVIDEND_W = 44,
  parameter int unsigned DIVISOR_W  = 11
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  done_o,
  output logic [DIVIDEND_W-1:0] quotient_o
);

  localparam int unsigned CNTW = $clog2(DIVIDEND_W + 1);

  logic                  busy_q;
  logic                  done_q;
  logic [CNTW-1:0]       cnt_q;
  logic [DIVISOR_W-1:0]  rem_q;
  logic [DIVISOR_W-1:0]  divisor_q;
  logic [DIVIDEND_W-1:0] quo_q;

  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  // Shift in the next dividend bit and trial-subtract the divisor.
  always_comb begin
    shifted = {rem_q, quo_q[DIVIDEND_W-1]};
    fits    = shifted >= {1'b0, divisor_q};
    diff    = shifted - {1'b0, divisor_q};
  end

  // Sequence the steps.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNTW'(DIVIDEND_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Load operands, then advance remainder and quotient one bit a cycle.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q     <= '0;
      quo_q     <= dividend_i;
      divisor_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
      quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== sv/mpv_checker.sv =====
// Port-level checks for the mean and population variance core, with bind.
module mpv_checker
  import mpv_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEFAULT
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input logic [SAMPLE_WIDTH-1:0] sample_i,
  input logic                    last_i,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic [SAMPLE_WIDTH-1:0] mean_o,
  input logic [VAR_W-1:0]        variance_o,
  input logic                    overflowed_o
);

  // A stalled input beat holds its value.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(sample_i) && $stable(last_i))
    else $error("input beat changed while stalled");

  // A stalled result beat holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(mean_o) &&
      $stable(variance_o) && $stable(overflowed_o))
    else $error("result beat changed while stalled");

  // The core goes busy right after taking the last beat of a set.
  a_busy_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && last_i |=> in_stall_o)
    else $error("input taken right after last beat");

  // A new result comes only out of the compute phase.
  a_result_from_compute: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared while loading");

  // No result comes straight out of reset.
  a_quiet_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid at reset release");

endmodule

bind mean_and_population_variance_core mpv_checker #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_mpv_checker (.*);
